/* hw/rtl/base32_crc16_key_decoder_unit_defines.svh */
// Assertion macros shared by the key decoder RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef BASE32_CRC16_KEY_DECODER_UNIT_DEFINES_SVH
`define BASE32_CRC16_KEY_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define B32CRC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define B32CRC_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);
`else
`define B32CRC_ASSERT(lbl, ck, rs, prop, msg)
`define B32CRC_NEVER(lbl, ck, rs, expr, msg)
`endif
`endif

/* hw/rtl/b32crc_pkg.sv */
// Shared types, constants and helper functions for the key decoder.
// No dependencies; imported by the core, the result queue and the top level.
`timescale 1ns / 1ps

package b32crc_pkg;

  localparam int unsigned MAX_BYTES_DEFAULT = 128;
  localparam int unsigned RESULT_DEPTH      = 4;

  localparam logic [31:0] VALID_PREFIX_MASK_RESET    = 32'd9494533;
  localparam logic [31:0] SEEDABLE_PREFIX_MASK_RESET = 32'd9461765;

  localparam logic [4:0]  SEED_TAG         = 5'd18;
  localparam int unsigned SEED_FRAME_BYTES = 36;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_INIT         = 16'h0000;

  // Configuration register indexes
  localparam logic REG_VALID_PREFIX_MASK    = 1'b0;
  localparam logic REG_SEEDABLE_PREFIX_MASK = 1'b1;

  // Final status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ILLEGAL     = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
  localparam logic [2:0] ST_CRC_FAIL    = 3'd3;
  localparam logic [2:0] ST_SEED_SIZE   = 3'd4;
  localparam logic [2:0] ST_SEED_PREFIX = 3'd5;
  localparam logic [2:0] ST_PREFIX      = 3'd6;
  localparam logic [2:0] ST_TOO_LONG    = 3'd7;

  typedef struct packed {
    logic       is_final;
    logic [7:0] payload_byte;
    logic [2:0] status_code;
    logic [7:0] prefix_value;
    logic       seed_flag;
    logic [7:0] payload_count;
  } result_t;

  // Write flags for the results put into the queue in one cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic sym_legal(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h32 && c <= 8'h37);
  endfunction

  function automatic logic [4:0] sym_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else                          v = c - 8'h32 + 8'd26;
    return v[4:0];
  endfunction

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* hw/rtl/b32crc_core.sv */
// Per-character decode step: input register, Base32 unpack, delay line, CRC, status.
// Depends on b32crc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "base32_crc16_key_decoder_unit_defines.svh"

module b32crc_core
  import b32crc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] valid_prefix_mask,
  input  logic [31:0] seedable_prefix_mask,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_string,
  input  logic        room,
  output push_t       push,
  output result_t     res0,
  output result_t     res1
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eos;
  logic       fire;

  logic [11:0]     bit_buffer, bit_buffer_next;
  logic [2:0]      bits_pending, bits_pending_next;
  logic [CntW-1:0] byte_count, byte_count_next;
  logic [7:0]      tail0, tail0_next, tail1, tail1_next;
  logic [15:0]     crc_register, crc_register_next;
  logic [7:0]      head0, head0_next, head1, head1_next;
  logic [2:0]      error_latch, error_latch_next;
  logic [7:0]      emitted_count, emitted_count_next;

  logic [3:0]  pend_sum;
  logic [7:0]  new_byte;
  logic        emit;
  logic        seed_cur, seed_new;
  logic [4:0]  vt_cur, vt_new;
  logic [7:0]  prefix_cur, prefix_new;
  logic [2:0]  status;
  result_t     pay_res, fin_res;

  assign fire     = s1_valid && room;
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char <= char_code;
      s1_eos  <= end_of_string;
    end
  end

  assign seed_cur   = (byte_count != '0) && (head0[7:3] == SEED_TAG);
  assign vt_cur     = {head0[2:0], head1[7:6]};
  assign prefix_cur = seed_cur ? {vt_cur, 3'b000} : head0;

  always_comb begin
    bit_buffer_next    = bit_buffer;
    bits_pending_next  = bits_pending;
    byte_count_next    = byte_count;
    tail0_next         = tail0;
    tail1_next         = tail1;
    crc_register_next  = crc_register;
    head0_next         = head0;
    head1_next         = head1;
    error_latch_next   = error_latch;
    emitted_count_next = emitted_count;
    emit               = 1'b0;
    pend_sum           = 4'd0;
    new_byte           = 8'd0;
    if (!sym_legal(s1_char)) begin
      error_latch_next = ST_ILLEGAL;
    end else if (error_latch == ST_OK) begin
      bit_buffer_next = {bit_buffer[6:0], sym_value(s1_char)};
      pend_sum        = {1'b0, bits_pending} + 4'd5;
      if (pend_sum >= 4'd8) begin
        bits_pending_next = 3'(pend_sum - 4'd8);
        new_byte          = 8'(bit_buffer_next >> bits_pending_next);
        if (byte_count >= CntW'(MAX_BYTES)) begin
          error_latch_next = ST_TOO_LONG;
        end else begin
          if (byte_count == CntW'(0)) head0_next = new_byte;
          if (byte_count == CntW'(1)) head1_next = new_byte;
          if (byte_count >= CntW'(2)) begin
            crc_register_next = crc_update(crc_register, tail0);
            // payload starts at raw byte 2 in seed frames, raw byte 1 otherwise
            if (byte_count >= (seed_cur ? CntW'(4) : CntW'(3))) begin
              emit               = 1'b1;
              emitted_count_next = emitted_count + 8'd1;
            end
          end
          tail0_next      = tail1;
          tail1_next      = new_byte;
          byte_count_next = byte_count + CntW'(1);
        end
      end else begin
        bits_pending_next = pend_sum[2:0];
      end
    end
  end

  assign seed_new   = (byte_count_next != '0) && (head0_next[7:3] == SEED_TAG);
  assign vt_new     = {head0_next[2:0], head1_next[7:6]};
  assign prefix_new = seed_new ? {vt_new, 3'b000} : head0_next;

  always_comb begin
    if (error_latch_next != ST_OK) begin
      status = error_latch_next;
    end else if (byte_count_next < CntW'(3)) begin
      status = ST_TOO_SHORT;
    end else if ({tail1_next, tail0_next} != crc_register_next) begin
      status = ST_CRC_FAIL;
    end else if (seed_new) begin
      if (byte_count_next != CntW'(SEED_FRAME_BYTES)) status = ST_SEED_SIZE;
      else if (!seedable_prefix_mask[vt_new])        status = ST_SEED_PREFIX;
      else                                            status = ST_OK;
    end else if (head0_next[2:0] != 3'd0 || !valid_prefix_mask[head0_next[7:3]]) begin
      status = ST_PREFIX;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pay_res               = '0;
    pay_res.payload_byte  = tail0;
    pay_res.prefix_value  = prefix_cur;
    pay_res.seed_flag     = seed_cur;
    pay_res.payload_count = emitted_count_next;

    fin_res               = '0;
    fin_res.is_final      = 1'b1;
    fin_res.status_code   = status;
    fin_res.prefix_value  = prefix_new;
    fin_res.seed_flag     = seed_new;
    fin_res.payload_count = emitted_count_next;

    res0        = emit ? pay_res : fin_res;
    res1        = fin_res;
    push.first  = fire && (emit || s1_eos);
    push.second = fire && emit && s1_eos;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && s1_eos)) begin
      bit_buffer    <= '0;
      bits_pending  <= '0;
      byte_count    <= '0;
      tail0         <= '0;
      tail1         <= '0;
      crc_register  <= CRC_INIT;
      head0         <= '0;
      head1         <= '0;
      error_latch   <= ST_OK;
      emitted_count <= '0;
    end else if (fire) begin
      bit_buffer    <= bit_buffer_next;
      bits_pending  <= bits_pending_next;
      byte_count    <= byte_count_next;
      tail0         <= tail0_next;
      tail1         <= tail1_next;
      crc_register  <= crc_register_next;
      head0         <= head0_next;
      head1         <= head1_next;
      error_latch   <= error_latch_next;
      emitted_count <= emitted_count_next;
    end
  end

  `B32CRC_ASSERT(a_run_cleared, clk, rst, fire && s1_eos |=> byte_count == '0 && error_latch == ST_OK, "run state not cleared after final status")
  `B32CRC_ASSERT(a_error_sticky, clk, rst, error_latch != ST_OK && !(fire && s1_eos) |=> error_latch != ST_OK, "latched error lost before end of string")
  `B32CRC_NEVER(a_emit_bound, clk, rst, 9'(emitted_count) > 9'(byte_count), "more payload bytes emitted than decoded")

endmodule

/* hw/rtl/b32crc_fifo.sv */
// Small result queue: up to two writes and one read per cycle.
// Depends on b32crc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "base32_crc16_key_decoder_unit_defines.svh"

module b32crc_fifo
  import b32crc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t din0,
  input  result_t din1,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  localparam int unsigned PtrW = $clog2(RESULT_DEPTH);
  localparam int unsigned CntW = $clog2(RESULT_DEPTH + 1);

  result_t         mem [RESULT_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [1:0]      n_push;

  assign n_push    = {1'b0, push.first} + {1'b0, push.second};
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = mem[rd_ptr];
  // leave space for a payload byte plus a final status
  assign room      = (count <= CntW'(RESULT_DEPTH - 2));

  assign count_next = count + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first)  mem[wr_ptr] <= din0;
    if (push.second) mem[wr_ptr + PtrW'(1)] <= din1;
  end

  `B32CRC_NEVER(a_no_overflow, clk, rst, count > CntW'(RESULT_DEPTH), "result queue overflow")
  `B32CRC_NEVER(a_push_order, clk, rst, push.second && !push.first, "second write without first")
  `B32CRC_NEVER(a_push_when_full, clk, rst, push.first && !room, "write into queue without space")

endmodule

/* hw/rtl/base32_crc16_key_decoder_unit.sv */
// Top level of the Base32 key decoder with CRC-16/XMODEM check.
// Instantiates b32crc_core and b32crc_fifo; depends on b32crc_pkg.
`timescale 1ns / 1ps

// Decodes a Base32 key string (A-Z, 2-7, no padding) one character per
// transfer and streams out the confirmed payload bytes, followed by one final
// status result on the character flagged end_of_string. The last two raw
// bytes are the little-endian CRC-16/XMODEM and are held in a two-byte delay
// line, so a payload byte appears only once two newer bytes have arrived.
// Throughput is one character per clock: the decode, delay line, CRC byte
// update and status check all sit in one stage between the input register
// and a four-entry result queue. A character can produce two results (a
// payload byte and the final status); the queue drains one per clock, so the
// input stalls only when the consumer stalls or two results back up. A
// transfer is first captured in the input register; its results are written
// into the queue when that character is taken, which waits for queue room.
// The consumer must discard the payload bytes of a string unless its final
// status is zero. Write the prefix masks only while no string is in flight.
module base32_crc16_key_decoder_unit
  import b32crc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // character input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_string,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_final,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status_code,
  output logic [7:0]  prefix_value,
  output logic        seed_flag,
  output logic [7:0]  payload_count
);

  logic [31:0] valid_prefix_mask;
  logic [31:0] seedable_prefix_mask;
  logic        room;
  push_t       push;
  result_t     res0, res1, head_res;

  // Prefix mask registers; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_prefix_mask    <= VALID_PREFIX_MASK_RESET;
      seedable_prefix_mask <= SEEDABLE_PREFIX_MASK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_VALID_PREFIX_MASK:    valid_prefix_mask    <= cfg_data;
        REG_SEEDABLE_PREFIX_MASK: seedable_prefix_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode step: registers the character, then updates run state and
  // produces zero, one or two results for the queue at once
  b32crc_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk                  (clk),
    .rst                  (rst),
    .valid_prefix_mask    (valid_prefix_mask),
    .seedable_prefix_mask (seedable_prefix_mask),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .char_code            (char_code),
    .end_of_string        (end_of_string),
    .room                 (room),
    .push                 (push),
    .res0                 (res0),
    .res1                 (res1)
  );

  // Hold results until the consumer takes them
  b32crc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (head_res)
  );

  assign is_final      = head_res.is_final;
  assign payload_byte  = head_res.payload_byte;
  assign status_code   = head_res.status_code;
  assign prefix_value  = head_res.prefix_value;
  assign seed_flag     = head_res.seed_flag;
  assign payload_count = head_res.payload_count;

endmodule

/* tb/tb.sv */
// Self-checking testbench for base32_crc16_key_decoder_unit: key strings in, payload and status out.
// Predicts each result with its own decoder and CRC model or a typed row; compares field by field.
// Depends on b32crc_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
  import b32crc_pkg::*;

  typedef logic [7:0] octet_q[$];

  // Kinds of key string the random part builds
  typedef enum int {
    SHAPE_KEY,       // well-formed key, prefix mostly accepted
    SHAPE_SEED,      // well-formed 36-byte seed frame
    SHAPE_ANY_HEAD,  // good CRC, any head byte, 3 to 43 raw bytes
    SHAPE_BAD_CRC,   // one bit flipped after the CRC was appended
    SHAPE_TOO_LONG,  // more raw bytes than the block keeps
    SHAPE_ILLEGAL,   // one character outside the alphabet
    SHAPE_NOISE,     // a few arbitrary characters
    SHAPE_CUT        // well-formed key with its tail chopped off
  } shape_e;
  localparam int NUM_SHAPES = 8;

  localparam int PHASES       = 6;
  localparam int PHASE_CHARS  = 120;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_LIMIT  = 50000;

  typedef struct {
    logic [7:0] chr;
    logic       eos;
    bit         typed;   // final result typed in below instead of predicted
    logic [2:0] status;
    logic [7:0] prefix;
    logic       seed;
  } probe_row_t;

  // Short strings whose final status reads off at a glance, then a plain
  // key ("hello") whose payload and status come from the predictor.
  probe_row_t probe_rows[23] = '{
    '{"0",   1'b1, 1'b1, ST_ILLEGAL,   8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b1, ST_ILLEGAL,   8'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b1, ST_ILLEGAL,   8'h00, 1'b0},
    '{"A",   1'b1, 1'b1, ST_TOO_SHORT, 8'h00, 1'b0},
    '{"7",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"Z",   1'b1, 1'b1, ST_TOO_SHORT, 8'hFE, 1'b0},
    '{"S",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"H",   1'b1, 1'b1, ST_TOO_SHORT, 8'h20, 1'b1},
    '{"A",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"a",   1'b1, 1'b1, ST_ILLEGAL,   8'h00, 1'b0},
    '{"A",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"A",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"A",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"A",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"A",   1'b1, 1'b1, ST_OK,        8'h00, 1'b0},
    '{"N",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"B",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"S",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"W",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"Y",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"3",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"D",   1'b0, 1'b0, ST_OK,        8'h00, 1'b0},
    '{"P",   1'b1, 1'b0, ST_OK,        8'h00, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = REG_VALID_PREFIX_MASK;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_final;
  logic [7:0]  payload_byte;
  logic [2:0]  status_code;
  logic [7:0]  prefix_value;
  logic        seed_flag;
  logic [7:0]  payload_count;

  base32_crc16_key_decoder_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_final      (is_final),
    .payload_byte  (payload_byte),
    .status_code   (status_code),
    .prefix_value  (prefix_value),
    .seed_flag     (seed_flag),
    .payload_count (payload_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder model: mirror of the per-string state and the two masks
  // ---------------------------------------------------------------------
  logic [31:0] prefix_ok_mask = VALID_PREFIX_MASK_RESET;
  logic [31:0] seed_ok_mask   = SEEDABLE_PREFIX_MASK_RESET;

  logic [11:0] key_bits;
  int          key_nbits;
  int          key_len;
  logic [7:0]  key_tail[2];   // [0] is the older byte of the delay line
  logic [15:0] key_crc;
  logic [7:0]  key_head[2];
  logic [2:0]  key_err;
  logic [7:0]  key_emitted;

  // Results the unit still owes, oldest first
  result_t key_results_q[$];

  int fail_count;
  int chars_sent;
  int frames_built;
  bit src_calm;
  int sink_hold;
  bit sink_calm;

  function automatic logic [15:0] xmodem_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic int symbol_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "2" && c <= "7") return int'(c - "2") + 26;
    return -1;
  endfunction

  function automatic logic [7:0] symbol_char(input logic [4:0] sym);
    if (sym < 5'd26) return "A" + 8'(sym);
    return "2" + 8'(sym) - 8'd26;
  endfunction

  function automatic bit key_is_seed();
    return key_len > 0 && key_head[0][7:3] == SEED_TAG;
  endfunction

  // Seed type index: low three bits of byte 0 then top two of byte 1
  function automatic logic [4:0] key_type_index();
    return {key_head[0][2:0], key_head[1][7:6]};
  endfunction

  function automatic logic [2:0] key_status();
    if (key_err != ST_OK) return key_err;
    if (key_len < 3) return ST_TOO_SHORT;
    if ({key_tail[1], key_tail[0]} != key_crc) return ST_CRC_FAIL;
    if (key_is_seed()) begin
      if (key_len != SEED_FRAME_BYTES) return ST_SEED_SIZE;
      if (!seed_ok_mask[key_type_index()]) return ST_SEED_PREFIX;
      return ST_OK;
    end
    if (key_head[0][2:0] != 3'b000 || !prefix_ok_mask[key_head[0][7:3]]) return ST_PREFIX;
    return ST_OK;
  endfunction

  task automatic post_result(input logic fin, input logic [7:0] data, input logic [2:0] status);
    result_t r;
    r.is_final      = fin;
    r.payload_byte  = data;
    r.status_code   = status;
    r.prefix_value  = key_is_seed() ? {key_type_index(), 3'b000} : key_head[0];
    r.seed_flag     = key_is_seed();
    r.payload_count = key_emitted;
    key_results_q.insert(key_results_q.size(), r);
  endtask

  task automatic clear_key();
    key_bits    = '0;
    key_nbits   = 0;
    key_len     = 0;
    key_tail    = '{8'h00, 8'h00};
    key_crc     = CRC_INIT;
    key_head    = '{8'h00, 8'h00};
    key_err     = ST_OK;
    key_emitted = '0;
  endtask

  // Advance the model by one accepted character and queue what it yields
  task automatic decode_key_char(input logic [7:0] c, input logic eos);
    int         v;
    logic [7:0] nb;
    int         first_out;
    v = symbol_index(c);
    if (v < 0) begin
      key_err = ST_ILLEGAL;   // overrides a latched overflow
    end else if (key_err == ST_OK) begin
      key_bits  = {key_bits[6:0], v[4:0]};
      key_nbits += 5;
      if (key_nbits >= 8) begin
        key_nbits -= 8;
        nb = 8'(key_bits >> key_nbits);
        if (key_len >= MAX_BYTES_DEFAULT) begin
          key_err = ST_TOO_LONG;
        end else begin
          if (key_len < 2) begin
            key_head[key_len] = nb;
          end else begin
            // the byte leaving the delay line enters the CRC and, past the head, is confirmed payload
            first_out = key_is_seed() ? 2 : 1;
            key_crc = xmodem_step(key_crc, key_tail[0]);
            if (key_len - 2 >= first_out) begin
              key_emitted++;
              post_result(1'b0, key_tail[0], ST_OK);
            end
          end
          key_tail[0] = key_tail[1];
          key_tail[1] = nb;
          key_len++;
        end
      end
    end
    if (eos) begin
      post_result(1'b1, 8'h00, key_status());
      clear_key();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Prefer an index whose mask bit is set; give up after a while
  function automatic logic [4:0] pick_set_bit(input logic [31:0] mask);
    logic [4:0] i;
    i = '0;
    repeat (64) begin
      i = 5'($urandom);
      if (mask[i]) return i;
    end
    return i;
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (symbol_index(c) >= 0) c = 8'($urandom);
    return c;
  endfunction

  function automatic shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return SHAPE_KEY;
    if (r < 62) return SHAPE_SEED;
    if (r < 72) return SHAPE_ANY_HEAD;
    if (r < 80) return SHAPE_BAD_CRC;
    if (r < 83) return SHAPE_TOO_LONG;
    if (r < 90) return SHAPE_ILLEGAL;
    if (r < 95) return SHAPE_NOISE;
    return SHAPE_CUT;
  endfunction

  // Build raw bytes with a trailing little-endian CRC, then encode to Base32 (noise is built as characters)
  function automatic octet_q make_frame(input shape_e shape);
    octet_q      raw;
    octet_q      chars;
    logic [15:0] crc;
    logic [15:0] acc;
    logic [4:0]  vt;
    logic [4:0]  sym;
    int          len;
    int          n;
    int          pos;
    crc = CRC_INIT;
    acc = '0;
    n   = 0;
    case (shape)
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 12))
          chars.insert(chars.size(),
                       $urandom_range(0, 1) ? symbol_char(5'($urandom)) : 8'($urandom));
        return chars;
      end
      SHAPE_SEED: begin
        vt = ($urandom_range(0, 3) != 0) ? pick_set_bit(seed_ok_mask) : 5'($urandom);
        raw.insert(raw.size(), {SEED_TAG, vt[4:2]});
        raw.insert(raw.size(), {vt[1:0], 6'($urandom)});
        len = SEED_FRAME_BYTES - 4;
      end
      SHAPE_ANY_HEAD: begin
        raw.insert(raw.size(),
                   $urandom_range(0, 1) ? {SEED_TAG, 3'($urandom)} : 8'($urandom));
        len = $urandom_range(0, 40);
      end
      SHAPE_TOO_LONG: begin
        raw.insert(raw.size(), 8'($urandom));
        len = $urandom_range(MAX_BYTES_DEFAULT - 2, MAX_BYTES_DEFAULT + 6);
      end
      default: begin
        raw.insert(raw.size(),
                   ($urandom_range(0, 3) != 0) ? {pick_set_bit(prefix_ok_mask), 3'b000}
                                               : 8'($urandom));
        // now and then fill the frame to exactly the byte limit
        len = ($urandom_range(0, 19) == 0) ? MAX_BYTES_DEFAULT - 3 : $urandom_range(0, 24);
      end
    endcase
    repeat (len) raw.insert(raw.size(), 8'($urandom));
    foreach (raw[i]) crc = xmodem_step(crc, raw[i]);
    raw.insert(raw.size(), crc[7:0]);
    raw.insert(raw.size(), crc[15:8]);
    if (shape == SHAPE_BAD_CRC) begin
      pos = $urandom_range(0, raw.size() - 1);
      raw[pos] = raw[pos] ^ (8'd1 << $urandom_range(0, 7));
    end

    foreach (raw[i]) begin
      acc = {acc[7:0], raw[i]};
      n += 8;
      while (n >= 5) begin
        n -= 5;
        sym = 5'(acc >> n);
        chars.insert(chars.size(), symbol_char(sym));
      end
    end
    // fill the slack bits of the last symbol with junk; the block drops them
    if (n > 0) begin
      sym = 5'((acc << (5 - n)) | $urandom_range(0, (1 << (5 - n)) - 1));
      chars.insert(chars.size(), symbol_char(sym));
    end

    if (shape == SHAPE_ILLEGAL)
      chars.insert($urandom_range(0, chars.size() - 1), stray_char());
    // an illegal last character must win over the latched overflow
    if (shape == SHAPE_TOO_LONG && $urandom_range(0, 1))
      chars.insert(chars.size(), stray_char());
    if (shape == SHAPE_CUT)
      repeat ($urandom_range(1, 3)) void'(chars.pop_back());
    return chars;
  endfunction

  // Offer one character, hold it until the transfer, then feed the model
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_key_char(c, eos);
    chars_sent++;
  endtask

  // Wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    int waited;
    waited = 0;
    while (key_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Write both masks back to back; drop the write enable once
  task automatic write_masks(input logic [31:0] key_mask, input logic [31:0] seed_mask);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_VALID_PREFIX_MASK;
    cfg_data     <= key_mask;
    @(posedge clk);
    cfg_index    <= REG_SEEDABLE_PREFIX_MASK;
    cfg_data     <= seed_mask;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    prefix_ok_mask = key_mask;
    seed_ok_mask   = seed_mask;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls and the field-by-field compare
  // ---------------------------------------------------------------------
  task automatic check_result();
    result_t got;
    result_t want;
    got = {is_final, payload_byte, status_code, prefix_value, seed_flag, payload_count};
    if (key_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected result final=%0d byte=%02h status=%0d prefix=%02h seed=%0d count=%0d",
                 $realtime, got.is_final, got.payload_byte, got.status_code,
                 got.prefix_value, got.seed_flag, got.payload_count);
    end else begin
      want = key_results_q.pop_front();
      if (got.is_final !== want.is_final || got.payload_byte !== want.payload_byte ||
          got.status_code !== want.status_code || got.prefix_value !== want.prefix_value ||
          got.seed_flag !== want.seed_flag || got.payload_count !== want.payload_count) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%0t: mismatch expected final=%0d byte=%02h status=%0d prefix=%02h seed=%0d count=%0d",
                   $realtime, want.is_final, want.payload_byte, want.status_code,
                   want.prefix_value, want.seed_flag, want.payload_count);
          $display("%0t:          actual   final=%0d byte=%02h status=%0d prefix=%02h seed=%0d count=%0d",
                   $realtime, got.is_final, got.payload_byte, got.status_code,
                   got.prefix_value, got.seed_flag, got.payload_count);
        end
      end
    end
  endtask

  // Sample the transfer with pre-edge values, then pick the next ready level.
  // Mostly short stalls, a few long ones, and calm stretches with none.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (sink_calm || $urandom_range(0, 99) >= 30) begin
      out_ready <= 1'b1;
    end else begin
      sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end
    if ($urandom_range(0, 255) == 0) sink_calm = !sink_calm;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    octet_q     chars;
    result_t    typed_result;
    shape_e     shape;
    int         phase_start;
    logic [31:0] key_mask;
    logic [31:0] seed_mask;

    clear_key();
    fail_count   = 0;
    chars_sent   = 0;
    frames_built = 0;
    src_calm     = 1'b0;
    sink_hold    = 0;
    sink_calm    = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings under the reset masks
    foreach (probe_rows[i]) begin
      send_char(probe_rows[i].chr, probe_rows[i].eos);
      if (probe_rows[i].typed) begin
        typed_result.is_final      = 1'b1;
        typed_result.payload_byte  = 8'h00;
        typed_result.status_code   = probe_rows[i].status;
        typed_result.prefix_value  = probe_rows[i].prefix;
        typed_result.seed_flag     = probe_rows[i].seed;
        typed_result.payload_count = 8'h00;
        void'(key_results_q.pop_back());
        key_results_q.insert(key_results_q.size(), typed_result);
      end
    end
    in_valid <= 1'b0;
    settle();

    // Random strings, one mask setting per phase; change masks only when idle
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin key_mask = '1;                      seed_mask = '1;                         end
        1: begin key_mask = '0;                      seed_mask = '0;                         end
        2: begin key_mask = $urandom;                seed_mask = $urandom;                   end
        3: begin key_mask = 32'h8000_0000;           seed_mask = 32'h7FFF_FFFF;              end
        4: begin key_mask = VALID_PREFIX_MASK_RESET; seed_mask = SEEDABLE_PREFIX_MASK_RESET; end
        default: begin key_mask = $urandom;          seed_mask = $urandom;                   end
      endcase
      write_masks(key_mask, seed_mask);

      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        // walk every shape once before going random
        shape = (frames_built < NUM_SHAPES) ? shape_e'(frames_built) : pick_shape();
        frames_built++;
        chars = make_frame(shape);
        src_calm = ($urandom_range(0, 4) == 0);
        foreach (chars[k])
          send_char(chars[k], k == chars.size() - 1);
      end
      in_valid <= 1'b0;
      settle();
    end

    repeat (10) @(posedge clk);
    fail_count += key_results_q.size();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/b32crc_pkg.sv
hw/rtl/b32crc_core.sv
hw/rtl/b32crc_fifo.sv
hw/rtl/base32_crc16_key_decoder_unit.sv
tb/tb.sv
